[sv/jpeg_marker_segment_parser_defines.svh]
// Assertion macros for the JPEG marker segment parser checker.
// Depends on nothing; included by the checker file.
`ifndef JPEG_MARKER_SEGMENT_PARSER_DEFINES_SVH
`define JPEG_MARKER_SEGMENT_PARSER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define JPMSP_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("jpmsp assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define JPMSP_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("jpmsp assertion failed");

`endif

[sv/jpmsp_pkg.sv]
// Shared types and codes of the JPEG marker segment parser.
// No dependencies; used by the interfaces, the top level and the checker.
`timescale 1ns / 1ps

package jpmsp_pkg;

  // Components beyond this position are dropped.
  localparam int MAX_COMPONENTS = 4;

  // Marker type bytes.
  localparam logic [7:0] MRK_PREFIX = 8'hff;
  localparam logic [7:0] MRK_SOI    = 8'hd8;
  localparam logic [7:0] MRK_EOI    = 8'hd9;
  localparam logic [7:0] MRK_TEM    = 8'h01;
  localparam logic [7:0] MRK_RST0   = 8'hd0;
  localparam logic [7:0] MRK_RST7   = 8'hd7;
  localparam logic [7:0] MRK_SOF0   = 8'hc0;
  localparam logic [7:0] MRK_SOS    = 8'hda;
  localparam logic [7:0] MRK_DQT    = 8'hdb;
  localparam logic [7:0] MRK_DHT    = 8'hc4;

  // Result kinds.
  localparam logic [2:0] KIND_FRAME_SIZE = 3'd0;
  localparam logic [2:0] KIND_FRAME_COMP = 3'd1;
  localparam logic [2:0] KIND_QUANT      = 3'd2;
  localparam logic [2:0] KIND_HUFF       = 3'd3;
  localparam logic [2:0] KIND_SCAN_COMP  = 3'd4;
  localparam logic [2:0] KIND_DATA       = 3'd5;
  localparam logic [2:0] KIND_END        = 3'd6;

  // Closing status codes.
  localparam logic [1:0] STATUS_OK      = 2'd0;
  localparam logic [1:0] STATUS_NO_SCAN = 2'd1;
  localparam logic [1:0] STATUS_BAD_LEN = 2'd2;

  typedef struct packed {
    logic [7:0] byte_req;
    logic       last;
  } in_beat_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [3:0]  index;
    logic        is_ac;
    logic [11:0] position;
    logic [15:0] value;
    logic [15:0] height;
    logic [7:0]  comp_id;
    logic [3:0]  nibble_high;
    logic [3:0]  nibble_low;
    logic [7:0]  extra_byte;
    logic        end_res;
    logic [1:0]  status;
  } out_beat_t;

endpackage

[sv/jpmsp_if.sv]
// Valid/ready channel interfaces for the input bytes and the results.
// Depends on jpmsp_pkg for the beat types.
`timescale 1ns / 1ps

interface jpmsp_in_if;
  logic                 valid;
  logic                 ready;
  jpmsp_pkg::in_beat_t  data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface jpmsp_out_if;
  logic                 valid;
  logic                 ready;
  jpmsp_pkg::out_beat_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

[sv/jpeg_marker_segment_parser.sv]
// JPEG marker segment parser: one file byte a beat in, at most one result a beat out.
// Depends on jpmsp_pkg and the channel interfaces in jpmsp_if.sv.
`timescale 1ns / 1ps

// The parser accepts one file byte in every clock cycle but for the stall named
// below, and delivers a result if the byte makes one. A byte is captured in an
// input register; one pass of logic then updates the parse state and fills the
// output register, which holds a result until it is taken while the next byte
// is already being parsed. Only a result that cannot enter a full, stalled
// output register holds the input side back; bytes without a result never
// stall. There is no clearing pass after reset. A byte flagged as last closes
// the stream and returns the parser to its reset state.
module jpeg_marker_segment_parser (
  input  logic         clk,
  input  logic         rst_n,
  jpmsp_in_if.sink     in_bus,
  jpmsp_out_if.source  out_bus
);
  import jpmsp_pkg::*;

  // Parse mode codes.
  localparam logic [2:0] MODE_SEEK = 3'd0;
  localparam logic [2:0] MODE_TYPE = 3'd1;
  localparam logic [2:0] MODE_LENH = 3'd2;
  localparam logic [2:0] MODE_LENL = 3'd3;
  localparam logic [2:0] MODE_BODY = 3'd4;
  localparam logic [2:0] MODE_DATA = 3'd5;
  localparam logic [2:0] MODE_BAD  = 3'd6;

  localparam logic [7:0] COMP_LIMIT = 8'(MAX_COMPONENTS);
  localparam logic [7:0] CK_SAT     = 8'hff;

  // Input register.
  logic       s1_valid_r;
  logic [7:0] s1_byte_r;
  logic       s1_last_r;

  // Parse state.
  logic [2:0]  mode_r, mode_nxt;
  logic [7:0]  marker_r, marker_nxt;
  logic [15:0] left_r, left_nxt;
  logic [15:0] pos_r, pos_nxt;
  logic [3:0]  tid_r, tid_nxt;
  logic        wide_r, wide_nxt;
  logic        ac_r, ac_nxt;
  logic [7:0]  held_r, held_nxt;
  logic [15:0] fh_r, fh_nxt;
  logic [15:0] fw_r, fw_nxt;
  logic [7:0]  ccount_r, ccount_nxt;
  logic [7:0]  cid_r, cid_nxt;
  logic [7:0]  csamp_r, csamp_nxt;
  logic [11:0] htotal_r, htotal_nxt;
  logic        scan_r, scan_nxt;
  // Frame component counter and byte phase within a component.
  logic [7:0]  ck_r, ck_nxt;
  logic [1:0]  cm_r, cm_nxt;

  // Output register.
  logic      out_valid_r;
  out_beat_t out_data_r;

  out_beat_t   res;
  logic        have;
  logic        s1_go;
  logic [15:0] seg_len;
  logic [15:0] pm1;
  logic [15:0] pm2;
  logic [15:0] pm17;
  logic [14:0] sk;
  logic [7:0]  b;

  assign b    = s1_byte_r;
  assign pm1  = pos_r - 16'd1;
  assign pm2  = pos_r - 16'd2;
  assign pm17 = pos_r - 16'd17;
  assign sk   = pm1[15:1];
  assign seg_len = {held_r, b};

  // The staged byte moves on unless its result finds the output register blocked.
  assign s1_go = s1_valid_r && (!have || !out_valid_r || out_bus.ready);
  assign in_bus.ready = !s1_valid_r || s1_go;

  // Parse one byte: next state and the result it makes.
  always_comb begin
    mode_nxt   = mode_r;
    marker_nxt = marker_r;
    left_nxt   = left_r;
    pos_nxt    = pos_r;
    tid_nxt    = tid_r;
    wide_nxt   = wide_r;
    ac_nxt     = ac_r;
    held_nxt   = held_r;
    fh_nxt     = fh_r;
    fw_nxt     = fw_r;
    ccount_nxt = ccount_r;
    cid_nxt    = cid_r;
    csamp_nxt  = csamp_r;
    htotal_nxt = htotal_r;
    scan_nxt   = scan_r;
    ck_nxt     = ck_r;
    cm_nxt     = cm_r;
    res        = '0;
    have       = 1'b0;

    case (mode_r)
      MODE_SEEK: begin
        if (b == MRK_PREFIX) mode_nxt = MODE_TYPE;
      end
      MODE_TYPE: begin
        // Fill bytes keep us here; standalone markers carry no length word.
        if (b != MRK_PREFIX) begin
          marker_nxt = b;
          if (b inside {MRK_SOI, MRK_EOI, MRK_TEM, [MRK_RST0:MRK_RST7]}) begin
            mode_nxt = MODE_SEEK;
          end else begin
            mode_nxt = MODE_LENH;
          end
        end
      end
      MODE_LENH: begin
        held_nxt = b;
        mode_nxt = MODE_LENL;
      end
      MODE_LENL: begin
        if (seg_len < 16'd2) begin
          mode_nxt = MODE_BAD;
        end else begin
          left_nxt = seg_len - 16'd2;
          pos_nxt  = 16'd0;
          if (seg_len == 16'd2) begin
            if (marker_r == MRK_SOS) begin
              scan_nxt = 1'b1;
              mode_nxt = MODE_DATA;
            end else begin
              mode_nxt = MODE_SEEK;
            end
          end else begin
            mode_nxt = MODE_BODY;
          end
        end
      end
      MODE_BODY: begin
        pos_nxt  = pos_r + 16'd1;
        left_nxt = left_r - 16'd1;
        if (left_r == 16'd1) begin
          if (marker_r == MRK_SOS) begin
            scan_nxt = 1'b1;
            mode_nxt = MODE_DATA;
          end else begin
            mode_nxt = MODE_SEEK;
          end
        end

        // Body decode by segment type.
        case (marker_r)
          MRK_SOF0: begin
            if (pos_r == 16'd1) begin
              fh_nxt = {b, 8'h00};
            end else if (pos_r == 16'd2) begin
              fh_nxt = {fh_r[15:8], b};
            end else if (pos_r == 16'd3) begin
              fw_nxt = {b, 8'h00};
            end else if (pos_r == 16'd4) begin
              fw_nxt = {fw_r[15:8], b};
            end else if (pos_r == 16'd5) begin
              ccount_nxt     = b;
              ck_nxt         = 8'd0;
              cm_nxt         = 2'd0;
              res.kind       = KIND_FRAME_SIZE;
              res.value      = fw_r;
              res.height     = fh_r;
              res.extra_byte = b;
              have           = 1'b1;
            end else if (pos_r >= 16'd6) begin
              // Three bytes per component: id, sampling, quant selector.
              case (cm_r)
                2'd0: cid_nxt = b;
                2'd1: csamp_nxt = b;
                default: begin
                  if (ck_r < ccount_r && ck_r < COMP_LIMIT) begin
                    res.kind        = KIND_FRAME_COMP;
                    res.index       = ck_r[3:0];
                    res.comp_id     = cid_r;
                    res.nibble_high = csamp_r[7:4];
                    res.nibble_low  = csamp_r[3:0];
                    res.extra_byte  = b;
                    have            = 1'b1;
                  end
                end
              endcase
              if (cm_r == 2'd2) begin
                cm_nxt = 2'd0;
                if (ck_r != CK_SAT) ck_nxt = ck_r + 8'd1;
              end else begin
                cm_nxt = cm_r + 2'd1;
              end
            end
          end
          MRK_DQT: begin
            if (pos_r == 16'd0) begin
              tid_nxt  = b[3:0];
              wide_nxt = |b[7:4];
            end else if (wide_r) begin
              // 16-bit entries, high byte first.
              if (pos_r <= 16'd128) begin
                if (pos_r[0]) begin
                  held_nxt = b;
                end else begin
                  res.kind     = KIND_QUANT;
                  res.index    = tid_r;
                  res.position = pm2[12:1];
                  res.value    = {held_r, b};
                  have         = 1'b1;
                end
              end
            end else if (pos_r <= 16'd64) begin
              res.kind     = KIND_QUANT;
              res.index    = tid_r;
              res.position = pm1[11:0];
              res.value    = {8'h00, b};
              have         = 1'b1;
            end
          end
          MRK_DHT: begin
            if (pos_r == 16'd0) begin
              tid_nxt    = b[3:0];
              ac_nxt     = |b[7:4];
              htotal_nxt = 12'd0;
            end else if (pos_r <= 16'd16 || pm17 < {4'h0, htotal_r}) begin
              // Count bytes add to the symbol total; symbols stop at that total.
              if (pos_r <= 16'd16) htotal_nxt = htotal_r + {4'h0, b};
              res.kind     = KIND_HUFF;
              res.index    = tid_r;
              res.is_ac    = ac_r;
              res.position = pm1[11:0];
              res.value    = {8'h00, b};
              have         = 1'b1;
            end
          end
          MRK_SOS: begin
            if (pos_r == 16'd0) begin
              ccount_nxt = b;
            end else if (!pm1[0]) begin
              cid_nxt = b;
            end else if (sk < {7'h00, ccount_r} && sk < {7'h00, COMP_LIMIT}) begin
              res.kind        = KIND_SCAN_COMP;
              res.index       = sk[3:0];
              res.comp_id     = cid_r;
              res.nibble_high = b[7:4];
              res.nibble_low  = b[3:0];
              have            = 1'b1;
            end
          end
          default: ;
        endcase
      end
      MODE_DATA: begin
        res.kind  = KIND_DATA;
        res.value = {8'h00, b};
        have      = 1'b1;
      end
      default: ;
    endcase

    // The last byte of the file always makes a closing result.
    if (s1_last_r) begin
      if (!have) begin
        res      = '0;
        res.kind = KIND_END;
        have     = 1'b1;
      end
      res.end_res = 1'b1;
      if (mode_nxt == MODE_BAD) begin
        res.status = STATUS_BAD_LEN;
      end else if (!scan_nxt) begin
        res.status = STATUS_NO_SCAN;
      end else begin
        res.status = STATUS_OK;
      end
    end
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_bus.ready) begin
      s1_valid_r <= in_bus.valid;
    end
    if (in_bus.ready && in_bus.valid) begin
      s1_byte_r <= in_bus.data.byte_req;
      s1_last_r <= in_bus.data.last;
    end
  end

  // Parse state; the closing byte returns it to reset values.
  always_ff @(posedge clk) begin
    if (!rst_n || (s1_go && s1_last_r)) begin
      mode_r   <= MODE_SEEK;
      marker_r <= '0;
      left_r   <= '0;
      pos_r    <= '0;
      tid_r    <= '0;
      wide_r   <= 1'b0;
      ac_r     <= 1'b0;
      held_r   <= '0;
      fh_r     <= '0;
      fw_r     <= '0;
      ccount_r <= '0;
      cid_r    <= '0;
      csamp_r  <= '0;
      htotal_r <= '0;
      scan_r   <= 1'b0;
      ck_r     <= '0;
      cm_r     <= '0;
    end else if (s1_go) begin
      mode_r   <= mode_nxt;
      marker_r <= marker_nxt;
      left_r   <= left_nxt;
      pos_r    <= pos_nxt;
      tid_r    <= tid_nxt;
      wide_r   <= wide_nxt;
      ac_r     <= ac_nxt;
      held_r   <= held_nxt;
      fh_r     <= fh_nxt;
      fw_r     <= fw_nxt;
      ccount_r <= ccount_nxt;
      cid_r    <= cid_nxt;
      csamp_r  <= csamp_nxt;
      htotal_r <= htotal_nxt;
      scan_r   <= scan_nxt;
      ck_r     <= ck_nxt;
      cm_r     <= cm_nxt;
    end
  end

  // Output register: loads a result, holds it until the beat is taken.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_go && have) begin
      out_valid_r <= 1'b1;
    end else if (out_bus.ready) begin
      out_valid_r <= 1'b0;
    end
    if (s1_go && have) begin
      out_data_r <= res;
    end
  end

  assign out_bus.valid = out_valid_r;
  assign out_bus.data  = out_data_r;

endmodule

[sv/jpmsp_checker.sv]
// Port-level assertions for the JPEG marker segment parser, bound to the top level.
// Depends on jpmsp_pkg and the macros in jpeg_marker_segment_parser_defines.svh.
`timescale 1ns / 1ps
`include "jpeg_marker_segment_parser_defines.svh"

module jpmsp_checker (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 out_valid,
  input logic                 out_ready,
  input jpmsp_pkg::out_beat_t out_data
);
  import jpmsp_pkg::*;

  logic out_stall;
  logic open_beat;
  logic end_only_ok;
  logic data_ok;

  // Conditions used by the checks below.
  assign out_stall   = out_valid && !out_ready;
  assign open_beat   = out_valid && !out_data.end_res;
  assign end_only_ok = out_data.end_res && out_data.value == 16'd0 &&
                       out_data.comp_id == 8'd0;
  assign data_ok     = out_data.value[15:8] == 8'd0 && out_data.height == 16'd0 &&
                       out_data.index == 4'd0;

  // A stalled result beat keeps its valid and its payload.
  `JPMSP_ASSERT_NXT(a_out_hold, clk, rst_n, out_stall, out_valid && $stable(out_data))

  // Only the closing beat carries a nonzero status.
  `JPMSP_ASSERT_IMP(a_status_end, clk, rst_n, open_beat, out_data.status == STATUS_OK)

  // An end-only beat is always a closing beat with zero value and component id.
  `JPMSP_ASSERT_IMP(a_end_only, clk, rst_n, out_valid && out_data.kind == KIND_END, end_only_ok)

  // Entropy data beats carry only a byte in value.
  `JPMSP_ASSERT_IMP(a_data_beat, clk, rst_n, out_valid && out_data.kind == KIND_DATA, data_ok)

endmodule

bind jpeg_marker_segment_parser jpmsp_checker u_jpmsp_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_bus.valid),
  .out_ready (out_bus.ready),
  .out_data  (out_bus.data)
);
